@@ design/i2r_pkg.sv @@
// Shared types, constants and glyph lookup for the integer to radix digits block.
package i2r_pkg;

  localparam int ValueW  = 64;
  localparam int DigW    = 4;
  localparam int RadixW  = 5;
  localparam int CharW   = 8;
  localparam int CountW  = 7;
  localparam int RegIdxW = 1;

  localparam logic [RegIdxW-1:0] RegRadix = 1'd0;
  localparam logic [RegIdxW-1:0] RegUpper = 1'd1;

  localparam logic [RadixW-1:0] RadixReset = 5'd10;
  localparam logic [RadixW-1:0] RadixMin   = 5'd2;
  localparam logic [RadixW-1:0] RadixMax   = 5'd16;

  localparam logic [CharW-1:0] AsciiZero  = 8'h30;
  localparam logic [CharW-1:0] AsciiLower = 8'h61;
  localparam logic [CharW-1:0] AsciiUpper = 8'h41;

  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
    logic bit_in;
  } cell_ctl_t;

  function automatic logic [CharW-1:0] glyph(input logic [DigW-1:0] d, input logic upper);
    logic [CharW-1:0] dx;
    dx = CharW'(d);
    if (d < 4'd10) begin
      glyph = AsciiZero + dx;
    end else if (upper) begin
      glyph = AsciiUpper + dx - 8'd10;
    end else begin
      glyph = AsciiLower + dx - 8'd10;
    end
  endfunction

endpackage

@@ design/i2r_cells.sv @@
// Row of base-radix digit cells: doubles in one bit per cycle, then shifts digits out at the top.
module i2r_cells #(
  parameter int NCELLS = 64
) (
  input  logic                          clk,
  input  i2r_pkg::cell_ctl_t            ctl,
  input  logic [i2r_pkg::RadixW-1:0]    radix,
  output logic [i2r_pkg::DigW-1:0]      top_digit,
  output logic [NCELLS:0]               carry
);

  logic [i2r_pkg::DigW-1:0] dig_r   [NCELLS];
  logic [i2r_pkg::DigW-1:0] dig_nxt [NCELLS];
  logic [NCELLS-1:0]        gen;
  logic [NCELLS-1:0]        gen_or_prop;
  logic [NCELLS:0]          sum;

  always_comb begin
    for (int i = 0; i < NCELLS; i++) begin
      gen[i]         = {dig_r[i], 1'b0} >= radix;
      gen_or_prop[i] = {dig_r[i], 1'b1} >= radix;
    end
    sum = {1'b0, gen} + {1'b0, gen_or_prop} + (NCELLS+1)'(ctl.bit_in);
    carry[0]      = ctl.bit_in;
    carry[NCELLS] = sum[NCELLS];
    for (int i = 1; i < NCELLS; i++) begin
      carry[i] = sum[i] ^ gen[i] ^ gen_or_prop[i];
    end
    for (int i = 0; i < NCELLS; i++) begin
      dig_nxt[i] = i2r_pkg::DigW'({dig_r[i], carry[i]}
                   - (carry[i+1] ? radix : {i2r_pkg::RadixW{1'b0}}));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NCELLS; i++) begin
      if (ctl.clear) begin
        dig_r[i] <= '0;
      end else if (ctl.conv) begin
        dig_r[i] <= dig_nxt[i];
      end else if (ctl.shift) begin
        dig_r[i] <= (i == 0) ? '0 : dig_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign top_digit = dig_r[NCELLS-1];

endmodule

@@ design/integer_to_radix_digits.sv @@
// Top level: converts a signed or unsigned integer to ASCII digits in a set radix.
//
// Input channel in_*: in_tdata carries the value, in_tuser says it is signed.
// Result channel out_*: one item per digit, most significant first; in_tuser-like
// out_tuser flags a leading minus on the first item, out_tlast marks the final
// digit, which also carries the character count (sign included).
// Configuration: cfg_wen with cfg_addr 0 writes the radix (saturated to 2..16),
// cfg_addr 1 the letter case. Write only while no item is in flight.
// Each item runs in two phases: the conversion phase feeds one magnitude bit per
// cycle into the digit cell row, then the emit phase shifts the row up one digit
// per cycle while the output is free, leading zeros dropped.
// in_tready is high only between items; the next item is taken while the last
// result still waits in the output register.
// A stall on out_tready freezes the digit shift; nothing is lost.
// Reset (rst_n low, synchronous) empties the output, sets radix 10, lower case.
module integer_to_radix_digits #(
  parameter int VALUE_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2r_pkg::ValueW-1:0]        in_tdata,  // [63:0] value
  input  logic                              in_tuser,  // [0] is_signed
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata, // [7:0] digit_char, [14:8] char_count
  output logic                              out_tuser, // [0] minus_first
  output logic                              out_tlast,
  input  logic                              cfg_wen,
  input  logic [i2r_pkg::RegIdxW-1:0]       cfg_addr,
  input  logic [i2r_pkg::RadixW-1:0]        cfg_wdata
);

  localparam int NW = $clog2(VALUE_BITS + 1);
  localparam int CW = $clog2(VALUE_BITS);
  localparam int SW = NW + 1;
  localparam logic [CW-1:0] CntLast = CW'(VALUE_BITS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

  state_t                          state_r;
  logic [CW-1:0]                   cnt_r;
  logic [NW-1:0]                   n_r;
  logic [VALUE_BITS-1:0]           mag_r;
  logic                            neg_r;
  logic [i2r_pkg::RadixW-1:0]      radix_r;
  logic                            upper_r;
  logic                            out_tvalid_r;
  logic [i2r_pkg::CharW-1:0]       out_char_r;
  logic [i2r_pkg::CountW-1:0]      out_count_r;
  logic                            out_minus_r;
  logic                            out_last_r;

  logic [VALUE_BITS-1:0]           in_val;
  logic                            in_neg;
  logic                            out_free;
  logic                            lead_done;
  logic                            first_digit;
  logic [i2r_pkg::RadixW-1:0]      radix_sat;
  i2r_pkg::cell_ctl_t              cell_ctl;
  logic [i2r_pkg::DigW-1:0]        top_digit;
  logic [VALUE_BITS:0]             carry;

  assign in_val      = in_tdata[VALUE_BITS-1:0];
  assign in_neg      = in_tuser & in_val[VALUE_BITS-1];
  assign out_free    = !out_tvalid_r || out_tready;
  assign lead_done   = (SW'(cnt_r) + SW'(n_r)) >= SW'(VALUE_BITS);
  assign first_digit = (SW'(cnt_r) + SW'(n_r)) == SW'(VALUE_BITS);
  assign in_tready   = (state_r == ST_IDLE);

  always_comb begin
    if (cfg_wdata < i2r_pkg::RadixMin) begin
      radix_sat = i2r_pkg::RadixMin;
    end else if (cfg_wdata > i2r_pkg::RadixMax) begin
      radix_sat = i2r_pkg::RadixMax;
    end else begin
      radix_sat = cfg_wdata;
    end
  end

  always_comb begin
    cell_ctl.clear  = (state_r == ST_IDLE) && in_tvalid;
    cell_ctl.conv   = (state_r == ST_CONV);
    cell_ctl.shift  = (state_r == ST_EMIT) && out_free;
    cell_ctl.bit_in = mag_r[VALUE_BITS-1];
  end

  i2r_cells #(
    .NCELLS(VALUE_BITS)
  ) u_cells (
    .clk      (clk),
    .ctl      (cell_ctl),
    .radix    (radix_r),
    .top_digit(top_digit),
    .carry    (carry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= i2r_pkg::RadixReset;
      upper_r <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        i2r_pkg::RegRadix: radix_r <= radix_sat;
        i2r_pkg::RegUpper: upper_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      n_r          <= '0;
      cnt_r        <= '0;
    end else begin
      if (out_tready && !(state_r == ST_EMIT && lead_done)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            mag_r   <= in_neg ? ({VALUE_BITS{1'b0}} - in_val) : in_val;
            neg_r   <= in_neg;
            cnt_r   <= '0;
            n_r     <= NW'(1);
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_r <= {mag_r[VALUE_BITS-2:0], 1'b0};
          if (carry[n_r]) begin
            n_r <= n_r + NW'(1);
          end
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CntLast) begin
            cnt_r   <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            cnt_r <= cnt_r + CW'(1);
            if (lead_done) begin
              out_tvalid_r <= 1'b1;
              out_char_r   <= i2r_pkg::glyph(top_digit, upper_r);
              out_minus_r  <= neg_r && first_digit;
              out_last_r   <= (cnt_r == CntLast);
              out_count_r  <= (cnt_r == CntLast)
                              ? i2r_pkg::CountW'(n_r) + i2r_pkg::CountW'(neg_r)
                              : '0;
            end
            if (cnt_r == CntLast) begin
              cnt_r   <= '0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_count_r, out_char_r};
  assign out_tuser  = out_minus_r;
  assign out_tlast  = out_last_r;

  a_count_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[14:8] == 7'd0)
    else $error("char count on a non-final digit");

  a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[14:8] != 7'd0)
    else $error("final digit without char count");

  a_digits_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> n_r != '0)
    else $error("emitting with no digits counted");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV |=> !(in_tvalid && in_tready) || state_r == ST_IDLE)
    else $error("item accepted during conversion");

endmodule

@@ test/tb_integer_to_radix_digits.sv @@
// Testbench for integer_to_radix_digits: directed table and random numbers checked against a predictor.
`timescale 1ns / 1ps

module tb_integer_to_radix_digits;

  localparam int SETTLE     = 2 * 64 + 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 700;
  localparam int PHASES     = 6;
  localparam int PER_PHASE  = 66;

  typedef struct packed {
    logic [7:0] ch;
    logic       minus;
    logic       last;
    logic [6:0] count;
  } digit_exp_t;

  typedef struct packed {
    logic [4:0]  radix_raw;
    logic        upper;
    logic [63:0] value;
    logic        sgn;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_wen = 1'b0;
  logic [i2r_pkg::RegIdxW-1:0] cfg_addr = i2r_pkg::RegRadix;
  logic [i2r_pkg::RadixW-1:0]  cfg_wdata = '0;

  logic hold_req = 1'b0;

  digit_exp_t pending_digits[$];
  dir_row_t   dir_rows[$];
  string      dir_text[$];

  logic [4:0] cur_radix = 5'd10;
  logic       cur_upper = 1'b0;

  int errors = 0;
  int numbers_sent = 0;
  int digits_checked = 0;
  int cfg_writes = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  integer_to_radix_digits u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= 50) begin
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    end
  endtask

  // Predict the digit items of one number under the current settings.
  task automatic convert_to_digits(input logic [63:0] v, input logic sgn);
    logic [3:0]  digs [64];
    logic [63:0] mag;
    logic        neg;
    string       glyph_set;
    int          n;
    digit_exp_t  e;
    glyph_set = cur_upper ? "0123456789ABCDEF" : "0123456789abcdef";
    neg = sgn && v[63];
    mag = neg ? (64'd0 - v) : v;
    n = 0;
    do begin
      digs[n] = 4'(mag % 64'(cur_radix));
      mag = mag / 64'(cur_radix);
      n++;
    end while (mag != 0 && n < 64);
    for (int k = 0; k < n; k++) begin
      e.ch    = glyph_set[digs[n - 1 - k]];
      e.minus = (k == 0) && neg;
      e.last  = (k == n - 1);
      e.count = e.last ? 7'(n + (neg ? 1 : 0)) : 7'd0;
      pending_digits.push_back(e);
    end
  endtask

  task automatic queue_text(input string s);
    digit_exp_t e;
    int         first;
    first = (s[0] == "-") ? 1 : 0;
    for (int k = first; k < s.len(); k++) begin
      e.ch    = s[k];
      e.minus = (k == first) && (first == 1);
      e.last  = (k == s.len() - 1);
      e.count = e.last ? 7'(s.len()) : 7'd0;
      pending_digits.push_back(e);
    end
  endtask

  task automatic add_row(input logic [4:0] r, input logic u, input logic [63:0] v,
                         input logic s, input string text);
    dir_rows.push_back({r, u, v, s});
    dir_text.push_back(text);
  endtask

  task automatic send_number(input logic [63:0] v, input logic s);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 200)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= s;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    numbers_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_settings(input logic [4:0] r, input logic u);
    cfg_wen   <= 1'b1;
    cfg_addr  <= i2r_pkg::RegRadix;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_addr  <= i2r_pkg::RegUpper;
    cfg_wdata <= i2r_pkg::RadixW'(u);
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cur_radix = (r < 5'd2) ? 5'd2 : (r > 5'd16) ? 5'd16 : r;
    cur_upper = u;
    cfg_writes++;
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4, 5: return {$urandom, $urandom};
      6, 7: return {$urandom, $urandom} >> $urandom_range(0, 63);
      8: return 64'($urandom_range(0, 1000));
      default: return 64'd0 - 64'($urandom_range(1, 1000));
    endcase
  endfunction

  always @(posedge clk) begin : check_digits
    digit_exp_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_digits.size() == 0) begin
        report_mismatch("unexpected digit", out_tdata[7:0], 0);
      end else begin
        e = pending_digits.pop_front();
        if (out_tdata[7:0] != e.ch) report_mismatch("digit_char", out_tdata[7:0], e.ch);
        if (out_tuser != e.minus) report_mismatch("minus_first", out_tuser, e.minus);
        if (out_tlast != e.last) report_mismatch("last", out_tlast, e.last);
        if (out_tdata[14:8] != e.count) report_mismatch("char_count", out_tdata[14:8], e.count);
        digits_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : receiver
    int  mode;
    int  mode_left;
    int  tick;
    bit  hold_taken;
    logic ready;
    mode = 0;
    mode_left = 0;
    tick = 0;
    hold_taken = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          0: ready = 1'b1;
          1: ready = 1'($urandom_range(0, 1));
          2: ready = ($urandom_range(0, 7) != 0);
          default: ready = ((tick % 7) < 3);
        endcase
        out_tready <= ready;
      end
    end
  end

  initial begin : stimulus
    logic [4:0] prev_radix;
    logic       prev_upper;
    dir_row_t   row;
    logic [4:0] r;

    add_row(5'd10, 1'b0, 64'd0, 1'b0, "0");
    add_row(5'd10, 1'b0, 64'd0, 1'b1, "0");
    add_row(5'd10, 1'b0, '1, 1'b0, "18446744073709551615");
    add_row(5'd10, 1'b0, '1, 1'b1, "-1");
    add_row(5'd10, 1'b0, 64'h8000_0000_0000_0000, 1'b1, "-9223372036854775808");
    add_row(5'd10, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, "9223372036854775807");
    add_row(5'd10, 1'b0, 64'h8000_0000_0000_0000, 1'b0, "9223372036854775808");
    add_row(5'd1, 1'b0, '1, 1'b0, "");
    add_row(5'd1, 1'b0, 64'h8000_0000_0000_0000, 1'b1, "");
    add_row(5'd1, 1'b0, 64'd0, 1'b0, "0");
    add_row(5'd0, 1'b0, 64'd5, 1'b0, "101");
    add_row(5'd17, 1'b1, 64'hDEAD_BEEF_CAFE_F00D, 1'b0, "DEADBEEFCAFEF00D");
    add_row(5'd17, 1'b1, '1, 1'b1, "-1");
    add_row(5'd17, 1'b1, 64'hFEDC_BA98_7654_3210, 1'b0, "FEDCBA9876543210");
    add_row(5'd31, 1'b0, 64'h00AB_CDEF, 1'b0, "abcdef");
    add_row(5'd31, 1'b0, 64'h8000_0000_0000_0000, 1'b1, "-8000000000000000");
    add_row(5'd16, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b1, "123456789abcdef");
    add_row(5'd3, 1'b1, '1, 1'b0, "");
    add_row(5'd3, 1'b1, 64'h8000_0000_0000_0000, 1'b1, "");
    add_row(5'd11, 1'b1, 64'd10, 1'b0, "A");
    add_row(5'd11, 1'b1, 64'hFFFF_FFFF_FFFF_FFF6, 1'b1, "-A");
    add_row(5'd15, 1'b0, 64'd14, 1'b0, "e");
    add_row(5'd15, 1'b0, 64'd225, 1'b1, "100");
    add_row(5'd7, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, "");
    add_row(5'd2, 1'b0, 64'd1, 1'b0, "1");

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_radix = 5'd10;
    prev_upper = 1'b0;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.radix_raw != prev_radix || row.upper != prev_upper) begin
        wait_idle();
        write_settings(row.radix_raw, row.upper);
        prev_radix = row.radix_raw;
        prev_upper = row.upper;
      end
      send_number(row.value, row.sgn);
      if (dir_text[i].len() != 0) begin
        queue_text(dir_text[i]);
      end else begin
        convert_to_digits(row.value, row.sgn);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      r = (p == 0) ? 5'd2 : (p == 1) ? 5'd16 : 5'($urandom_range(0, 31));
      write_settings(r, 1'($urandom_range(0, 1)));
      for (int k = 0; k < PER_PHASE; k++) begin
        logic [63:0] v;
        logic        s;
        if (p == 2 && k == 3) hold_req <= 1'b1;
        v = pick_value();
        s = 1'($urandom_range(0, 1));
        send_number(v, s);
        convert_to_digits(v, s);
      end
    end

    wait_idle();
    $display("summary: %0d numbers converted, %0d digits checked, %0d register settings",
             numbers_sent, digits_checked, cfg_writes);
    $display("summary: radix 2..16 with saturating writes, both letter cases, long output stall");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ integer_to_radix_digits.f @@
design/i2r_pkg.sv
design/i2r_cells.sv
design/integer_to_radix_digits.sv
test/tb_integer_to_radix_digits.sv
